// ----- design/scps_pkg.sv -----
// Shared types, constants and helpers for the side contact point sampler.
package scps_pkg;

	// Ten distinct probe offsets exist along each axis; sides reuse them.
	localparam int unsigned NUM_OFFS = 10;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned THR_W    = 4;

	localparam logic [THR_W-1:0] THR_RESET = 4'd2;

	// Offset indexes along one axis (E = half extent, q = quarter, s = step).
	localparam int unsigned OFS_NEG_E_NEG_S = 0;
	localparam int unsigned OFS_NEG_S       = 1;
	localparam int unsigned OFS_POS_S       = 2;
	localparam int unsigned OFS_NEG_Q_NEG_S = 3;
	localparam int unsigned OFS_NEG_Q_POS_S = 4;
	localparam int unsigned OFS_POS_Q_NEG_S = 5;
	localparam int unsigned OFS_POS_Q_POS_S = 6;
	localparam int unsigned OFS_NEG_E_POS_S = 7;
	localparam int unsigned OFS_POS_E_NEG_S = 8;
	localparam int unsigned OFS_POS_E_POS_S = 9;

	typedef logic [NUM_OFFS-1:0] offs_mask_t;
	typedef logic [CNT_W-1:0]    hit_cnt_t;

	// Number of set bits in a ten-bit mask.
	function automatic hit_cnt_t count_hits(input offs_mask_t m);
		hit_cnt_t c;
		c = '0;
		for (int i = 0; i < NUM_OFFS; i++) begin
			c = c + hit_cnt_t'(m[i]);
		end
		return c;
	endfunction

endpackage

// ----- design/side_contact_point_sampler.sv -----
// Top level of the side contact point sampler pipeline.
//
// Usage: drive the object (pos_x, pos_y, half_w, half_h, step) and one
// rectangle (rect_x, rect_y, rect_w, rect_h) and pulse start. An item is
// taken at every clock edge with start high; busy is never raised, so a new
// item may follow in every cycle.
// The block tests 36 probe points around the step-grown box against the
// rectangle and reports per side whether the hit count reaches the
// threshold. Each result appears on hit_up, hit_right, hit_down and
// hit_left for exactly one cycle, marked by done, once its item has passed
// every pipeline stage. Throughput is one item per cycle, set by the five-stage
// pipeline (base sums, probe coordinates, edge compares, hit counts,
// threshold compare) with no shared unit.
// The threshold is written through cfg_valid/cfg_data; cfg_ready is always
// high. Write it only while no item is in flight.
// Reset clears all valid bits and sets the threshold to two. The receiver
// cannot stall, so nothing is ever held back.
module side_contact_point_sampler import scps_pkg::*; #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic        [COORD_WIDTH-2:0] half_w,
	input  logic        [COORD_WIDTH-2:0] half_h,
	input  logic        [COORD_WIDTH-2:0] step,
	input  logic signed [COORD_WIDTH-1:0] rect_x,
	input  logic signed [COORD_WIDTH-1:0] rect_y,
	input  logic        [COORD_WIDTH-2:0] rect_w,
	input  logic        [COORD_WIDTH-2:0] rect_h,
	output logic                          done,
	output logic                          hit_up,
	output logic                          hit_right,
	output logic                          hit_down,
	output logic                          hit_left,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [THR_W-1:0]              cfg_data
);

	// Two guard bits hold every sum of a coordinate and two extents.
	localparam int unsigned XW = COORD_WIDTH + 2;

	typedef logic signed [XW-1:0] coord_t;

	logic [THR_W-1:0] thr_q;

	coord_t pxe, pye, hwe, hhe, qxe, qye, rxe, rye;

	// Stage 1: base sums per axis.
	logic   vld_s1;
	coord_t px_s1, px_m_h_s1, px_p_h_s1, px_m_q_s1, px_p_q_s1;
	coord_t py_s1, py_m_h_s1, py_p_h_s1, py_m_q_s1, py_p_q_s1;
	coord_t st_s1, rx_s1, rx_end_s1, ry_s1, ry_end_s1;

	// Stage 2: the ten probe coordinates per axis.
	logic   vld_s2;
	coord_t xc_s2 [NUM_OFFS];
	coord_t yc_s2 [NUM_OFFS];
	coord_t rx_s2, rx_end_s2, ry_s2, ry_end_s2;

	// Stage 3: which coordinates fall inside the rectangle's span.
	logic       vld_s3;
	offs_mask_t xin_s3, yin_s3;

	// Stage 4: hit counts along each axis plus the outer row and column flags.
	logic     vld_s4;
	hit_cnt_t xcnt_s4, ycnt_s4;
	logic     top_s4, bot_s4, lft_s4, rgt_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	assign pxe = coord_t'(pos_x);
	assign pye = coord_t'(pos_y);
	assign rxe = coord_t'(rect_x);
	assign rye = coord_t'(rect_y);
	assign hwe = $signed({3'b000, half_w});
	assign hhe = $signed({3'b000, half_h});
	assign qxe = $signed({4'b0000, half_w[COORD_WIDTH-2:1]});
	assign qye = $signed({4'b0000, half_h[COORD_WIDTH-2:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s1     <= pxe;
		px_m_h_s1 <= pxe - hwe;
		px_p_h_s1 <= pxe + hwe;
		px_m_q_s1 <= pxe - qxe;
		px_p_q_s1 <= pxe + qxe;
		py_s1     <= pye;
		py_m_h_s1 <= pye - hhe;
		py_p_h_s1 <= pye + hhe;
		py_m_q_s1 <= pye - qye;
		py_p_q_s1 <= pye + qye;
		st_s1     <= $signed({3'b000, step});
		rx_s1     <= rxe;
		rx_end_s1 <= rxe + $signed({3'b000, rect_w});
		ry_s1     <= rye;
		ry_end_s1 <= rye + $signed({3'b000, rect_h});
	end

	always_ff @(posedge clk) begin
		xc_s2[OFS_NEG_E_NEG_S] <= px_m_h_s1 - st_s1;
		xc_s2[OFS_NEG_S]       <= px_s1 - st_s1;
		xc_s2[OFS_POS_S]       <= px_s1 + st_s1;
		xc_s2[OFS_NEG_Q_NEG_S] <= px_m_q_s1 - st_s1;
		xc_s2[OFS_NEG_Q_POS_S] <= px_m_q_s1 + st_s1;
		xc_s2[OFS_POS_Q_NEG_S] <= px_p_q_s1 - st_s1;
		xc_s2[OFS_POS_Q_POS_S] <= px_p_q_s1 + st_s1;
		xc_s2[OFS_NEG_E_POS_S] <= px_m_h_s1 + st_s1;
		xc_s2[OFS_POS_E_NEG_S] <= px_p_h_s1 - st_s1;
		xc_s2[OFS_POS_E_POS_S] <= px_p_h_s1 + st_s1;
		yc_s2[OFS_NEG_E_NEG_S] <= py_m_h_s1 - st_s1;
		yc_s2[OFS_NEG_S]       <= py_s1 - st_s1;
		yc_s2[OFS_POS_S]       <= py_s1 + st_s1;
		yc_s2[OFS_NEG_Q_NEG_S] <= py_m_q_s1 - st_s1;
		yc_s2[OFS_NEG_Q_POS_S] <= py_m_q_s1 + st_s1;
		yc_s2[OFS_POS_Q_NEG_S] <= py_p_q_s1 - st_s1;
		yc_s2[OFS_POS_Q_POS_S] <= py_p_q_s1 + st_s1;
		yc_s2[OFS_NEG_E_POS_S] <= py_m_h_s1 + st_s1;
		yc_s2[OFS_POS_E_NEG_S] <= py_p_h_s1 - st_s1;
		yc_s2[OFS_POS_E_POS_S] <= py_p_h_s1 + st_s1;
		rx_s2     <= rx_s1;
		rx_end_s2 <= rx_end_s1;
		ry_s2     <= ry_s1;
		ry_end_s2 <= ry_end_s1;
	end

	// Left and top edges are inside, right and bottom edges are not.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_OFFS; i++) begin
			xin_s3[i] <= (xc_s2[i] >= rx_s2) && (xc_s2[i] < rx_end_s2);
			yin_s3[i] <= (yc_s2[i] >= ry_s2) && (yc_s2[i] < ry_end_s2);
		end
	end

	// The top side uses every x offset on the topmost row, the bottom side on
	// the bottom row; the left and right sides use every y offset on the outer
	// columns. Corners are therefore counted by both sides that meet there.
	always_ff @(posedge clk) begin
		xcnt_s4 <= count_hits(xin_s3);
		ycnt_s4 <= count_hits(yin_s3);
		top_s4  <= yin_s3[OFS_NEG_E_NEG_S];
		bot_s4  <= yin_s3[OFS_POS_E_POS_S];
		lft_s4  <= xin_s3[OFS_NEG_E_NEG_S];
		rgt_s4  <= xin_s3[OFS_POS_E_POS_S];
	end

	// An empty row or column counts zero hits, which still meets a zero threshold.
	always_ff @(posedge clk) begin
		hit_up    <= (top_s4 ? xcnt_s4 : hit_cnt_t'(0)) >= thr_q;
		hit_right <= (rgt_s4 ? ycnt_s4 : hit_cnt_t'(0)) >= thr_q;
		hit_down  <= (bot_s4 ? xcnt_s4 : hit_cnt_t'(0)) >= thr_q;
		hit_left  <= (lft_s4 ? ycnt_s4 : hit_cnt_t'(0)) >= thr_q;
	end

endmodule
